@@ sv/sdfifo_pkg.sv @@
`timescale 1ns / 1ps
// Shared sizes, register codes and channel interface types for the sound DMA byte FIFO pair.
// No dependencies.
package sdfifo_pkg;

  localparam int FIFO_DEPTH   = 32;
  localparam int REFILL_LEVEL = 16;

  localparam int AW      = $clog2(FIFO_DEPTH);      // store index
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);  // fill count, holds FIFO_DEPTH
  localparam int PW      = AW + 2;                  // unwrapped tail position
  localparam int LEVEL_W = 6;                       // level port width
  localparam int BYTE_W  = 8;
  localparam int DATA_W  = 32;
  localparam int LANES   = DATA_W / BYTE_W;         // bytes in a word push
  localparam int HALF_LANES = 2;                    // bytes in a halfword push
  localparam int ACC_W   = $clog2(LANES + 1);
  localparam int TIMER_W = 2;
  localparam int CFG_AW  = 2;
  localparam int CFG_W   = 2;

  typedef enum logic [CFG_AW-1:0] {
    CFG_CHAN0_ENABLE = 2'd0,
    CFG_CHAN0_TIMER  = 2'd1,
    CFG_CHAN1_ENABLE = 2'd2,
    CFG_CHAN1_TIMER  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              valid;
    logic              is_word;
    logic [DATA_W-1:0] data;
  } push_t;

  typedef struct packed {
    logic [BYTE_W-1:0] front;
    logic [CNT_W-1:0]  count;
    logic              req;
    logic              dropped;
  } chan_res_t;

endpackage

@@ sv/sdfifo_chan.sv @@
`timescale 1ns / 1ps
// One byte FIFO channel: multi-byte push, single-byte pop, next-state status.
// Depends on sdfifo_pkg.
module sdfifo_chan import sdfifo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  input  logic      pop_i,
  output chan_res_t res_o
);

  logic [AW-1:0]     head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d, space;
  logic [BYTE_W-1:0] store_q [FIFO_DEPTH];
  logic [PW-1:0]     lane_pos  [LANES];
  logic [AW-1:0]     lane_addr [LANES];
  logic [LANES-1:0]  lane_en;
  logic [ACC_W-1:0]  n_acc;

  // tail lanes: byte i goes to head + count + i, wrapped once
  always_comb begin
    space = CNT_W'(FIFO_DEPTH) - count_q;
    n_acc = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_pos[i]  = PW'(head_q) + PW'(count_q) + PW'(i);
      lane_addr[i] = (lane_pos[i] >= PW'(FIFO_DEPTH)) ? AW'(lane_pos[i] - PW'(FIFO_DEPTH))
                                                       : AW'(lane_pos[i]);
      lane_en[i]   = push_i.valid && (push_i.is_word || (i < HALF_LANES)) &&
                     (CNT_W'(i) < space);
      n_acc        = n_acc + ACC_W'(lane_en[i]);
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q + CNT_W'(n_acc);
    if (pop_i && (count_q != '0)) begin
      head_d  = (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + AW'(1);
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    res_o.count   = count_d;
    res_o.dropped = push_i.valid &&
                    (!lane_en[HALF_LANES-1] || (push_i.is_word && !lane_en[LANES-1]));
    res_o.req     = pop_i && ((count_d == '0) || (32'(count_d) == REFILL_LEVEL));
    if (count_d == '0) begin
      res_o.front = '0;
    end else if (count_q == '0) begin
      // first byte of this push becomes the front
      res_o.front = push_i.data[BYTE_W-1:0];
    end else begin
      res_o.front = store_q[head_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      if (lane_en[i]) begin
        store_q[lane_addr[i]] <= push_i.data[i*BYTE_W +: BYTE_W];
      end
    end
  end

endmodule

@@ sv/sound_dma_byte_fifo_pair.sv @@
`timescale 1ns / 1ps
// Top level of the sound DMA byte FIFO pair: request register, two channels, result register.
// Depends on sdfifo_pkg and sdfifo_chan.
//
// Two 32-byte sample FIFOs. A request is taken on every clock where start_i is high (busy_o
// stays low), so the block sustains one request per cycle. Each request gives exactly one
// result: the request is registered at the accepting edge, both channels update their head,
// count and store in the following cycle, and the result register shows fronts, levels,
// refill requests and the overflow flag, strobed by result_valid_o for one cycle. The
// receiver cannot stall; results must be taken as they appear. The request rate is set by
// the channel update, a four-lane tail write and a head/count step. A write request pushes
// two bytes, or four with is_word_i, low byte first; bytes finding the FIFO full are dropped
// and flagged. A timer request pops one byte from each enabled channel on that timer and
// raises its refill request at level 16 or 0.
// Configuration writes are meant for idle periods only (nothing in flight).
module sound_dma_byte_fifo_pair import sdfifo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic               channel_i,
  input  logic [DATA_W-1:0]  write_data_i,
  input  logic               is_word_i,
  input  logic [TIMER_W-1:0] timer_index_i,
  input  logic               cfg_we_i,
  input  logic [CFG_AW-1:0]  cfg_addr_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  output logic               result_valid_o,
  output logic [BYTE_W-1:0]  sample0_o,
  output logic [BYTE_W-1:0]  sample1_o,
  output logic [LEVEL_W-1:0] level0_o,
  output logic [LEVEL_W-1:0] level1_o,
  output logic               dma_req0_o,
  output logic               dma_req1_o,
  output logic               overflowed_o
);

  // configuration
  logic               chan0_en_q, chan1_en_q;
  logic [TIMER_W-1:0] chan0_timer_q, chan1_timer_q;

  // request register
  logic               in_vld_q;
  logic               req_type_q, channel_q, is_word_q;
  logic [DATA_W-1:0]  write_data_q;
  logic [TIMER_W-1:0] timer_index_q;

  // result register
  logic               res_vld_q;
  logic [BYTE_W-1:0]  sample0_q, sample1_q;
  logic [LEVEL_W-1:0] level0_q, level1_q;
  logic               dma_req0_q, dma_req1_q, overflowed_q;

  push_t     push0, push1;
  logic      pop0, pop1;
  chan_res_t res0, res1;
  logic      accept;

  // never stalls: one request per cycle
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan0_en_q    <= 1'b0;
      chan0_timer_q <= '0;
      chan1_en_q    <= 1'b0;
      chan1_timer_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_CHAN0_ENABLE: chan0_en_q    <= cfg_wdata_i[0];
        CFG_CHAN0_TIMER:  chan0_timer_q <= TIMER_W'(cfg_wdata_i);
        CFG_CHAN1_ENABLE: chan1_en_q    <= cfg_wdata_i[0];
        CFG_CHAN1_TIMER:  chan1_timer_q <= TIMER_W'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q    <= req_type_i;
      channel_q     <= channel_i;
      write_data_q  <= write_data_i;
      is_word_q     <= is_word_i;
      timer_index_q <= timer_index_i;
    end
  end

  // steer the registered request: a write goes to one channel, a timer tick may pop both
  always_comb begin
    push0.valid   = in_vld_q && !req_type_q && !channel_q;
    push0.is_word = is_word_q;
    push0.data    = write_data_q;
    push1.valid   = in_vld_q && !req_type_q && channel_q;
    push1.is_word = is_word_q;
    push1.data    = write_data_q;
    pop0 = in_vld_q && req_type_q && chan0_en_q && (chan0_timer_q == timer_index_q);
    pop1 = in_vld_q && req_type_q && chan1_en_q && (chan1_timer_q == timer_index_q);
  end

  sdfifo_chan u_chan0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push0),
    .pop_i  (pop0),
    .res_o  (res0)
  );

  sdfifo_chan u_chan1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push1),
    .pop_i  (pop1),
    .res_o  (res1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      sample0_q    <= res0.front;
      sample1_q    <= res1.front;
      level0_q     <= LEVEL_W'(res0.count);
      level1_q     <= LEVEL_W'(res1.count);
      dma_req0_q   <= res0.req;
      dma_req1_q   <= res1.req;
      overflowed_q <= res0.dropped || res1.dropped;
    end
  end

  assign result_valid_o = res_vld_q;
  assign sample0_o      = sample0_q;
  assign sample1_o      = sample1_q;
  assign level0_o       = level0_q;
  assign level1_o       = level1_q;
  assign dma_req0_o     = dma_req0_q;
  assign dma_req1_o     = dma_req1_q;
  assign overflowed_o   = overflowed_q;

endmodule

@@ sv/sdfifo_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the sound DMA byte FIFO pair, bound to the top level.
// Depends on sdfifo_pkg.
module sdfifo_chk import sdfifo_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               result_valid_o,
  input logic [LEVEL_W-1:0] level0_o,
  input logic [LEVEL_W-1:0] level1_o,
  input logic               dma_req0_o,
  input logic               dma_req1_o,
  input logic               overflowed_o
);

  // every accepted request yields a result after the request and result registers
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && $past(rst_ni, 2) && $past(start_i && !busy_o, 2)) |-> result_valid_o)
    else $error("request without result");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i, 2))
    else $error("result without request");

  // channel 0 refill request only at the refill level or empty
  a_req0_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && dma_req0_o) |->
      ((level0_o == '0) || (level0_o == LEVEL_W'(REFILL_LEVEL))))
    else $error("channel 0 refill request at wrong level");

  // a drop only happens on a write, which leaves some FIFO full and raises no request
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && overflowed_o) |->
      (!dma_req0_o && !dma_req1_o &&
       ((level0_o == LEVEL_W'(FIFO_DEPTH)) || (level1_o == LEVEL_W'(FIFO_DEPTH)))))
    else $error("overflow flag without a full FIFO");

endmodule

bind sound_dma_byte_fifo_pair sdfifo_chk u_sdfifo_chk (.*);
